[rtl/core/ps_pack_header_parser_defines.svh]
// Assertion macros shared by the pack header parser RTL.
`ifndef PS_PACK_HEADER_PARSER_DEFINES_SVH
`define PS_PACK_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, checked on clock, off during reset.
`define PSPH_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psph assertion failed");

// Next-cycle implication, checked on clock, off during reset.
`define PSPH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psph assertion failed");

`endif

[rtl/core/psph_pkg.sv]
// Types, constants and field extraction for the pack header parser.
package psph_pkg;

   localparam int unsigned POS_W = 5;
   localparam int unsigned BODY_W = 80;

   localparam logic [31:0] PACK_SYNC_WORD = 32'h0000_01BA;

   localparam logic [POS_W-1:0] POS_BODY_FIRST = 5'd4;
   localparam logic [POS_W-1:0] POS_BODY_LAST  = 5'd13;
   localparam logic [POS_W-1:0] POS_STUFFING   = 5'd14;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BAD_SYNC = 1'b1;

   typedef struct packed {
      logic        valid;
      logic        status;
      logic [32:0] clock_ref_base;
      logic [8:0]  clock_ref_ext;
      logic [21:0] mux_rate;
      logic [2:0]  stuffing_count;
   } result_type;

   // Body bit p (first byte MSB is p = 0) sits at body[79-p].
   function automatic result_type extract_header(input logic [BODY_W-1:0] body);
      result_type r;
      r.valid          = 1'b1;
      r.status         = STATUS_OK;
      r.clock_ref_base = {body[77:75], body[73:59], body[57:43]};
      r.clock_ref_ext  = body[41:33];
      r.mux_rate       = body[31:10];
      r.stuffing_count = body[2:0];
      return r;
   endfunction

endpackage

[rtl/core/psph_parse_core.sv]
// Pack header parse state: start code sync, body capture, stuffing skip.
`include "ps_pack_header_parser_defines.svh"

module psph_parse_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             data_byte,
   output psph_pkg::result_type   result
);

   logic [psph_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [31:0]                 window_ff, window_in;
   logic                        hunting_ff, hunting_in;
   logic [psph_pkg::BODY_W-1:0] body_ff, body_in;
   logic [2:0]                  stuff_ff, stuff_in;
   logic [2:0]                  stuff_dec;

   always_comb begin
      pos_in     = pos_ff;
      window_in  = window_ff;
      hunting_in = hunting_ff;
      body_in    = body_ff;
      stuff_in   = stuff_ff;
      result     = '0;
      stuff_dec  = (stuff_ff == 3'd0) ? 3'd0 : stuff_ff - 3'd1;
      if (advance) begin
         priority if (hunting_ff) begin
            window_in = {window_ff[23:0], data_byte};
            if (window_in == psph_pkg::PACK_SYNC_WORD) begin
               hunting_in = 1'b0;
               pos_in     = psph_pkg::POS_BODY_FIRST;
            end
         end else if (pos_ff < psph_pkg::POS_BODY_FIRST) begin
            window_in = {window_ff[23:0], data_byte};
            pos_in    = pos_ff + 5'd1;
            if (pos_in == psph_pkg::POS_BODY_FIRST &&
                window_in != psph_pkg::PACK_SYNC_WORD) begin
               hunting_in    = 1'b1;
               result.valid  = 1'b1;
               result.status = psph_pkg::STATUS_BAD_SYNC;
            end
         end else if (pos_ff <= psph_pkg::POS_BODY_LAST) begin
            body_in = {body_ff[psph_pkg::BODY_W-9:0], data_byte};
            if (pos_ff == psph_pkg::POS_BODY_LAST) begin
               stuff_in = data_byte[2:0];
               if (data_byte[2:0] == 3'd0) begin
                  pos_in = '0;
                  result = psph_pkg::extract_header(body_in);
               end else begin
                  pos_in = psph_pkg::POS_STUFFING;
               end
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end else begin
            // drop the stuffing byte
            stuff_in = stuff_dec;
            if (stuff_dec == 3'd0) begin
               pos_in = '0;
               result = psph_pkg::extract_header(body_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         window_ff  <= '0;
         hunting_ff <= 1'b0;
         stuff_ff   <= '0;
      end else begin
         pos_ff     <= pos_in;
         window_ff  <= window_in;
         hunting_ff <= hunting_in;
         stuff_ff   <= stuff_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
   end

   `PSPH_ASSERT_NOW(a_pos_range, 1'b1, pos_ff <= psph_pkg::POS_STUFFING)
   `PSPH_ASSERT_NOW(a_hunt_pos, hunting_ff, pos_ff == psph_pkg::POS_BODY_FIRST)
   `PSPH_ASSERT_NOW(a_stuff_pos, stuff_ff != 3'd0, pos_ff == psph_pkg::POS_STUFFING)

endmodule

[rtl/core/ps_pack_header_parser.sv]
// Top level of the MPEG-2 program stream pack header parser.
//
// Usage: feed the program stream one byte per request on req_data_byte
// (req_valid / req_stall). Each pack header (start code 0x000001BA, ten body
// bytes, up to seven stuffing bytes) yields one response on rsp_* carrying
// the clock reference base and extension, mux rate and stuffing count, with
// rsp_status low. If the four start code bytes do not match, one response
// with rsp_status high and all other fields zero is given, and the parser
// hunts byte by byte for the next start code without further error responses.
// Path: an accepted request waits in the input register, is parsed from there, and
// its response is loaded into the response register that drives rsp_*.
// Throughput: one byte per cycle while rsp_stall does not hold a full response register.
// Stall: while rsp_stall holds a full response register, the parse stage
// stops; an empty input register still takes one more request, then req_stall
// rises. Reset (synchronous, active high) empties both registers and returns
// the parser to expecting a start code.
`include "ps_pack_header_parser_defines.svh"

module ps_pack_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [32:0] rsp_clock_ref_base,
   output logic [8:0]  rsp_clock_ref_ext,
   output logic [21:0] rsp_mux_rate,
   output logic [2:0]  rsp_stuffing_count
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff;
   psph_pkg::result_type rsp_ff;
   psph_pkg::result_type result;
   logic                 out_free;
   logic                 advance;
   logic                 in_ready;

   // Advance the parse stage only when its response has somewhere to go.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign in_ready  = !in_valid_ff || advance;
   assign req_stall = !in_ready;

   psph_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   // Input register: hold the byte until the parse stage takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // Response register: load when free, hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_clock_ref_base = rsp_ff.clock_ref_base;
   assign rsp_clock_ref_ext  = rsp_ff.clock_ref_ext;
   assign rsp_mux_rate       = rsp_ff.mux_rate;
   assign rsp_stuffing_count = rsp_ff.stuffing_count;

   `PSPH_ASSERT_NOW(a_err_zero, rsp_valid_ff && rsp_status,
      rsp_clock_ref_base == 33'd0 && rsp_clock_ref_ext == 9'd0 && rsp_mux_rate == 22'd0)
   `PSPH_ASSERT_NOW(a_full_accept, req_valid && !req_stall && in_valid_ff, advance)
   `PSPH_ASSERT_NEXT(a_no_drop, advance && result.valid, rsp_valid_ff)

endmodule

[test/pack_header_check_pkg.sv]
// Scoreboard for the pack header parser: bytewise header predictor and response checker.
package pack_header_check_pkg;

   import psph_pkg::*;

   typedef struct {
      logic        status;
      logic [32:0] clock_ref_base;
      logic [8:0]  clock_ref_ext;
      logic [21:0] mux_rate;
      logic [2:0]  stuffing_count;
   } header_fields_type;

   class pack_header_scoreboard;

      // Parser state mirrored from the stream seen so far.
      logic [4:0]     byte_pos;
      logic [31:0]    sync_window;
      bit             hunting;
      logic [79:0]    body_bits;
      logic [2:0]     stuffing_left;

      header_fields_type expected_headers[$];
      int unsigned       failures;

      function new();
         byte_pos      = '0;
         sync_window   = '0;
         hunting       = 1'b0;
         body_bits     = '0;
         stuffing_left = '0;
         failures      = 0;
      endfunction

      // Read count bits of the body, MSB first, starting at bit offset first.
      function logic [21:0] body_field(int unsigned first, int unsigned count);
         logic [21:0] v;
         int unsigned i;
         v = '0;
         for (i = 0; i < count; i++)
            v = {v[20:0], body_bits[79 - (first + i)]};
         return v;
      endfunction

      function void queue_parsed_header();
         header_fields_type h;
         logic [21:0]       part_hi, part_mid, part_lo;
         part_hi  = body_field(2, 3);
         part_mid = body_field(6, 15);
         part_lo  = body_field(22, 15);
         h.status         = STATUS_OK;
         h.clock_ref_base = {part_hi[2:0], part_mid[14:0], part_lo[14:0]};
         h.clock_ref_ext  = 9'(body_field(38, 9));
         h.mux_rate       = body_field(48, 22);
         h.stuffing_count = 3'(body_field(77, 3));
         expected_headers.insert(expected_headers.size(), h);
      endfunction

      function void note_request(logic [7:0] data);
         header_fields_type h;
         if (hunting) begin
            sync_window = {sync_window[23:0], data};
            if (sync_window == PACK_SYNC_WORD) begin
               hunting  = 1'b0;
               byte_pos = POS_BODY_FIRST;
            end
         end else if (byte_pos < POS_BODY_FIRST) begin
            sync_window = {sync_window[23:0], data};
            byte_pos++;
            if (byte_pos == POS_BODY_FIRST && sync_window != PACK_SYNC_WORD) begin
               hunting          = 1'b1;
               h.status         = STATUS_BAD_SYNC;
               h.clock_ref_base = '0;
               h.clock_ref_ext  = '0;
               h.mux_rate       = '0;
               h.stuffing_count = '0;
               expected_headers.insert(expected_headers.size(), h);
            end
         end else if (byte_pos <= POS_BODY_LAST) begin
            body_bits[8 * (POS_BODY_LAST - byte_pos) +: 8] = data;
            if (byte_pos == POS_BODY_LAST) begin
               stuffing_left = data[2:0];
               if (stuffing_left == 0) begin
                  byte_pos = '0;
                  queue_parsed_header();
               end else begin
                  byte_pos = POS_STUFFING;
               end
            end else begin
               byte_pos++;
            end
         end else begin
            if (stuffing_left != 0)
               stuffing_left--;
            if (stuffing_left == 0) begin
               byte_pos = '0;
               queue_parsed_header();
            end
         end
      endfunction

      function void check_response(logic status, logic [32:0] clock_ref_base,
                                   logic [8:0] clock_ref_ext, logic [21:0] mux_rate,
                                   logic [2:0] stuffing_count);
         header_fields_type e;
         if (expected_headers.size() == 0) begin
            $error("unexpected response: status %0h base %0h", status, clock_ref_base);
            failures++;
            return;
         end
         e = expected_headers.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0h, got %0h", e.status, status);
            failures++;
         end
         if (clock_ref_base !== e.clock_ref_base) begin
            $error("clock_ref_base: expected %0h, got %0h", e.clock_ref_base, clock_ref_base);
            failures++;
         end
         if (clock_ref_ext !== e.clock_ref_ext) begin
            $error("clock_ref_ext: expected %0h, got %0h", e.clock_ref_ext, clock_ref_ext);
            failures++;
         end
         if (mux_rate !== e.mux_rate) begin
            $error("mux_rate: expected %0h, got %0h", e.mux_rate, mux_rate);
            failures++;
         end
         if (stuffing_count !== e.stuffing_count) begin
            $error("stuffing_count: expected %0h, got %0h", e.stuffing_count, stuffing_count);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_headers.size();
      endfunction

   endclass

endpackage

[test/testbench.sv]
// Top-level testbench for the pack header parser: stream stimulus, idling phases, checks.
module testbench;

   import psph_pkg::*;
   import pack_header_check_pkg::*;

   // Start clock low and hold every block input at a known value from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_status;
   logic [32:0] rsp_clock_ref_base;
   logic [8:0]  rsp_clock_ref_ext;
   logic [21:0] rsp_mux_rate;
   logic [2:0]  rsp_stuffing_count;

   // Percent chance per cycle that the sender idles or the receiver stalls.
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned items_sent = 0;

   pack_header_scoreboard sb = new();

   always #4 clock = ~clock;

   ps_pack_header_parser u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_clock_ref_base (rsp_clock_ref_base),
      .rsp_clock_ref_ext  (rsp_clock_ref_ext),
      .rsp_mux_rate       (rsp_mux_rate),
      .rsp_stuffing_count (rsp_stuffing_count)
   );

   // Stall the response channel at random, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Check every response taken at this edge; values read here are the pre-edge ones,
   // the same ones the block sees.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_clock_ref_base, rsp_clock_ref_ext,
                           rsp_mux_rate, rsp_stuffing_count);
   end

   // Offer one byte, idle at random first, and hold it until the block takes it.
   // Keep valid high between back-to-back requests; drop it only inside an idle gap.
   task automatic send_byte(input logic [7:0] data);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(data);
      items_sent++;
   endtask

   task automatic send_start(input logic [31:0] code);
      int i;
      for (i = 3; i >= 0; i--)
         send_byte(code[8 * i +: 8]);
   endtask

   task automatic send_body(input logic [79:0] body);
      int i;
      for (i = 9; i >= 0; i--)
         send_byte(body[8 * i +: 8]);
   endtask

   task automatic send_noise(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++)
         send_byte(8'($urandom));
   endtask

   // Pause the sender until every expected response is back; always wait on the clock
   // so valid is never lowered and raised in the same step.
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   // Mix mostly well-formed packs with random content and a share of broken input:
   // corrupted start codes, raw noise (often landing in hunt mode) and cut-off headers.
   task automatic send_random_stream(input int unsigned target);
      int unsigned pick;
      logic [79:0] body;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         body = {16'($urandom), $urandom, $urandom};
         if (pick < 80) begin
            send_start(PACK_SYNC_WORD);
            send_body(body);
            send_noise(body[2:0]);
         end else if (pick < 88) begin
            send_start(PACK_SYNC_WORD ^ (32'h1 << $urandom_range(31)));
            send_body(body);
         end else if (pick < 95) begin
            send_noise($urandom_range(1, 20));
         end else begin
            send_start(PACK_SYNC_WORD);
            send_noise($urandom_range(1, 9));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: all-zero header with zero stuffing, then a bad start code that puts
      // the parser into hunt mode, then resync onto an all-ones header carrying the
      // full seven stuffing bytes, four of them spelling a start code to show that
      // stuffing content is dropped. Marker bits go both ways across the two headers.
      send_start(PACK_SYNC_WORD);
      send_body('0);
      send_start(PACK_SYNC_WORD ^ 32'h1);
      send_start(PACK_SYNC_WORD);
      send_body('1);
      send_start(PACK_SYNC_WORD);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h55);
      drain();

      // Random phases: no idling, sender idle, receiver stalling, both; drain between.
      send_random_stream(items_sent + 165);
      drain();
      idle_pct = 84;
      send_random_stream(items_sent + 165);
      drain();
      idle_pct  = 0;
      stall_pct = 84;
      send_random_stream(items_sent + 165);
      drain();
      idle_pct  = 35;
      stall_pct = 35;
      send_random_stream(items_sent + 165);

      // Wait for the last responses, then let the clock run on to catch stray ones.
      drain();
      repeat (8) @(posedge clock);
      if (sb.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin
      #(8 * 400000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
